/* design/stg_pkg.sv */
// Shared types, constants and the sine table of the sine tone generator with fade.
// Used by stg_divider and sine_tone_generator_with_fade_unit; depends on nothing.
`default_nettype none

package stg_pkg;

	localparam int TABLE_ENTRIES    = 360;
	localparam int SAMPLES_PER_MS   = 48;
	localparam int FADE_IN_SAMPLES  = 480;
	localparam int FADE_OUT_SAMPLES = 1680;
	localparam int BASE_RATE        = 48000;

	localparam int POS_W  = 22;
	localparam int PER_W  = 16;
	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int DIV_W  = 25;
	localparam int DEN_W  = 16;
	localparam int CNT_W  = $clog2(DIV_W + 1);
	localparam int FADE_W = 13;
	localparam int MAG_W  = 15;
	localparam int TOT_W  = 24;

	localparam logic [POS_W-1:0] MAX_POS = {POS_W{1'b1}};

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_IDLE   = 2'd1,
		STAT_REJECT = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PER_WAIT,
		ST_IDX_GO,
		ST_IDX_WAIT,
		ST_FIN_CHK,
		ST_FIN_WAIT,
		ST_FOUT_CHK,
		ST_FOUT_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	// One full turn of a Q15 sine in one-degree steps.
	localparam logic [15:0] SINE_ROM [TABLE_ENTRIES] = '{
		16'h0000, 16'h023C, 16'h0478, 16'h06B3, 16'h08EE, 16'h0B28, 16'h0D61, 16'h0F99,
		16'h11D0, 16'h1406, 16'h163A, 16'h186C, 16'h1A9D, 16'h1CCB, 16'h1EF7, 16'h2121,
		16'h2348, 16'h256C, 16'h278E, 16'h29AC, 16'h2BC7, 16'h2DDF, 16'h2FF3, 16'h3203,
		16'h3410, 16'h3618, 16'h381C, 16'h3A1C, 16'h3C17, 16'h3E0E, 16'h4000, 16'h41EC,
		16'h43D4, 16'h45B6, 16'h4793, 16'h496A, 16'h4B3C, 16'h4D08, 16'h4ECD, 16'h508D,
		16'h5246, 16'h53F9, 16'h55A5, 16'h574B, 16'h58EA, 16'h5A82, 16'h5C13, 16'h5D9C,
		16'h5F1F, 16'h609A, 16'h620D, 16'h6379, 16'h64DD, 16'h6639, 16'h678D, 16'h68D9,
		16'h6A1D, 16'h6B59, 16'h6C8C, 16'h6DB7, 16'h6ED9, 16'h6FF3, 16'h7104, 16'h720C,
		16'h730B, 16'h7401, 16'h74EE, 16'h75D2, 16'h76AD, 16'h777F, 16'h7847, 16'h7906,
		16'h79BB, 16'h7A67, 16'h7B0A, 16'h7BA2, 16'h7C32, 16'h7CB7, 16'h7D33, 16'h7DA5,
		16'h7E0D, 16'h7E6C, 16'h7EC0, 16'h7F0B, 16'h7F4B, 16'h7F82, 16'h7FAF, 16'h7FD2,
		16'h7FEB, 16'h7FFA, 16'h7FFF, 16'h7FFA, 16'h7FEB, 16'h7FD2, 16'h7FAF, 16'h7F82,
		16'h7F4B, 16'h7F0B, 16'h7EC0, 16'h7E6C, 16'h7E0D, 16'h7DA5, 16'h7D33, 16'h7CB7,
		16'h7C32, 16'h7BA2, 16'h7B0A, 16'h7A67, 16'h79BB, 16'h7906, 16'h7847, 16'h777F,
		16'h76AD, 16'h75D2, 16'h74EE, 16'h7401, 16'h730B, 16'h720C, 16'h7104, 16'h6FF3,
		16'h6ED9, 16'h6DB7, 16'h6C8C, 16'h6B59, 16'h6A1D, 16'h68D9, 16'h678D, 16'h6639,
		16'h64DD, 16'h6379, 16'h620D, 16'h609A, 16'h5F1F, 16'h5D9C, 16'h5C13, 16'h5A82,
		16'h58EA, 16'h574B, 16'h55A5, 16'h53F9, 16'h5246, 16'h508D, 16'h4ECD, 16'h4D08,
		16'h4B3C, 16'h496A, 16'h4793, 16'h45B6, 16'h43D4, 16'h41EC, 16'h3FFF, 16'h3E0E,
		16'h3C17, 16'h3A1C, 16'h381C, 16'h3618, 16'h3410, 16'h3203, 16'h2FF3, 16'h2DDF,
		16'h2BC7, 16'h29AC, 16'h278E, 16'h256C, 16'h2348, 16'h2121, 16'h1EF7, 16'h1CCB,
		16'h1A9D, 16'h186C, 16'h163A, 16'h1406, 16'h11D0, 16'h0F99, 16'h0D61, 16'h0B28,
		16'h08EE, 16'h06B3, 16'h0478, 16'h023C, 16'h0000, 16'hFDC4, 16'hFB88, 16'hF94D,
		16'hF712, 16'hF4D8, 16'hF29F, 16'hF067, 16'hEE30, 16'hEBFA, 16'hE9C6, 16'hE794,
		16'hE563, 16'hE335, 16'hE109, 16'hDEDF, 16'hDCB8, 16'hDA94, 16'hD872, 16'hD654,
		16'hD439, 16'hD221, 16'hD00D, 16'hCDFD, 16'hCBF0, 16'hC9E8, 16'hC7E4, 16'hC5E4,
		16'hC3E9, 16'hC1F2, 16'hC000, 16'hBE14, 16'hBC2C, 16'hBA4A, 16'hB86D, 16'hB696,
		16'hB4C4, 16'hB2F8, 16'hB133, 16'hAF73, 16'hADBA, 16'hAC07, 16'hAA5B, 16'hA8B5,
		16'hA716, 16'hA57E, 16'hA3ED, 16'hA264, 16'hA0E1, 16'h9F66, 16'h9DF3, 16'h9C87,
		16'h9B23, 16'h99C7, 16'h9873, 16'h9727, 16'h95E3, 16'h94A7, 16'h9374, 16'h9249,
		16'h9127, 16'h900D, 16'h8EFC, 16'h8DF4, 16'h8CF5, 16'h8BFF, 16'h8B12, 16'h8A2E,
		16'h8953, 16'h8881, 16'h87B9, 16'h86FA, 16'h8645, 16'h8599, 16'h84F6, 16'h845E,
		16'h83CE, 16'h8349, 16'h82CD, 16'h825B, 16'h81F3, 16'h8194, 16'h8140, 16'h80F5,
		16'h80B5, 16'h807E, 16'h8051, 16'h802E, 16'h8015, 16'h8006, 16'h8001, 16'h8006,
		16'h8015, 16'h802E, 16'h8051, 16'h807E, 16'h80B5, 16'h80F5, 16'h8140, 16'h8194,
		16'h81F3, 16'h825B, 16'h82CD, 16'h8349, 16'h83CE, 16'h845E, 16'h84F6, 16'h8599,
		16'h8645, 16'h86FA, 16'h87B9, 16'h8881, 16'h8953, 16'h8A2E, 16'h8B12, 16'h8BFF,
		16'h8CF5, 16'h8DF4, 16'h8EFC, 16'h900D, 16'h9127, 16'h9249, 16'h9374, 16'h94A7,
		16'h95E3, 16'h9727, 16'h9873, 16'h99C7, 16'h9B23, 16'h9C87, 16'h9DF3, 16'h9F66,
		16'hA0E1, 16'hA264, 16'hA3ED, 16'hA57E, 16'hA716, 16'hA8B5, 16'hAA5B, 16'hAC07,
		16'hADBA, 16'hAF73, 16'hB133, 16'hB2F8, 16'hB4C4, 16'hB696, 16'hB86D, 16'hBA4A,
		16'hBC2C, 16'hBE14, 16'hC001, 16'hC1F2, 16'hC3E9, 16'hC5E4, 16'hC7E4, 16'hC9E8,
		16'hCBF0, 16'hCDFD, 16'hD00D, 16'hD221, 16'hD439, 16'hD654, 16'hD872, 16'hDA94,
		16'hDCB8, 16'hDEDF, 16'hE109, 16'hE335, 16'hE563, 16'hE794, 16'hE9C6, 16'hEBFA,
		16'hEE30, 16'hF067, 16'hF29F, 16'hF4D8, 16'hF712, 16'hF94D, 16'hFB88, 16'hFDC4
	};

	// Table read; codes past the last entry read as zero.
	function automatic logic [15:0] sine_value(input logic [IDX_W-1:0] idx);
		logic [15:0] v;
		v = '0;
		if (idx < IDX_W'(TABLE_ENTRIES)) begin
			v = SINE_ROM[idx];
		end
		return v;
	endfunction

endpackage

`default_nettype wire

/* design/stg_divider.sv */
// Shared restoring divider of the tone generator, one quotient bit per cycle.
// Depends on stg_pkg for widths and the request and response structs.
`default_nettype none

module stg_divider (
	input  logic            clk,
	input  logic            arst_n,
	input  stg_pkg::div_req_t req,
	output stg_pkg::div_rsp_t rsp
);
	import stg_pkg::*;

	logic [DIV_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [DEN_W:0] shifted;
	logic [DEN_W:0] diff;
	logic           fits;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign fits    = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign rsp.busy     = cnt_q != '0;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

/* design/sine_tone_generator_with_fade_unit.sv */
// Top level of the sine tone generator with fade: configuration, sequencer, output register.
// Depends on stg_pkg and instantiates stg_divider.
`default_nettype none

// Channel  | Dir | Signals                          | Contents
// ---------+-----+----------------------------------+-----------------------------------------
// input    | in  | s_tvalid s_tready s_tdata[7:0]   | one word per tick: start_req in bit 0
// output   | out | m_tvalid m_tready m_tdata m_tlast| sample, last flag, status in m_tuser
//          |     | m_tuser[1:0]                     |
// config   | in  | cfg_we cfg_index cfg_data[15:0]  | 0 tone_freq, 1 duration_ms
//
// Every division runs through one 25-step restoring divider, which sets the rate. An advance
// word of a playing tone needs the index division, each active fade ramp adds one division,
// and a start word adds the period division before them. An idle word or a start at zero
// frequency needs no division, and a start rejected by its period needs only that division.
// The input is ready only while the sequencer is idle; a result waits in the output register
// while the next word is taken, and the sequencer holds its result if that register is full.
// Reset clears the tone state to idle and loads tone_freq 1000 and duration_ms 100.

module sine_tone_generator_with_fade_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] start_req, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] sample
	output logic        m_tlast,
	output logic [1:0]  m_tuser,   // [1:0] status
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import stg_pkg::*;

	// Configuration registers.
	logic [15:0] tone_freq_q;
	logic [15:0] duration_q;

	// Tone state.
	state_t           state_q, state_d;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] total_q;
	logic [PER_W-1:0] phase_q;
	logic [PER_W-1:0] period_q;
	logic             playing_q;

	// Result being built, then the output register.
	logic [15:0] smp_q;
	logic        last_q;
	status_t     status_q;
	logic        m_valid_q;
	logic [15:0] m_sample_q;
	logic        m_last_q;
	status_t     m_status_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                     accept;
	logic                     start_req;
	logic [TOT_W-1:0]         tot_prod;
	logic [POS_W-1:0]         tot_sat;
	logic                     per_ok;
	logic [PER_W:0]           phase_inc;
	logic [PER_W-1:0]         phase_nx;
	logic [DIV_W-1:0]         idx_dividend;
	logic [POS_W-1:0]         dist_end;
	logic                     fin_act;
	logic                     fout_act;
	logic                     last_nx;
	logic [15:0]              smp_abs;
	logic [FADE_W-1:0]        mul_b;
	logic [MAG_W+FADE_W-1:0]  mul_p;
	logic [15:0]              faded_mag;
	logic [15:0]              faded;
	logic                     out_free;

	stg_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_freq_q <= 16'd1000;
			duration_q  <= 16'd100;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) begin
				tone_freq_q <= cfg_data;
			end else begin
				duration_q <= cfg_data;
			end
		end
	end

	assign s_tready  = state_q == ST_IDLE;
	assign accept    = s_tvalid && s_tready;
	assign start_req = s_tdata[0];

	// Tone length in samples, saturated to the position counter.
	assign tot_prod = TOT_W'(duration_q) * TOT_W'(SAMPLES_PER_MS);
	assign tot_sat  = (tot_prod > TOT_W'(MAX_POS)) ? MAX_POS : tot_prod[POS_W-1:0];

	// The period must be nonzero and fit inside the tone.
	assign per_ok = (div_rsp.quotient != '0) &&
		(div_rsp.quotient <= DIV_W'(total_q));

	assign phase_inc = {1'b0, phase_q} + 1'b1;
	assign phase_nx  = (phase_inc >= {1'b0, period_q}) ? '0 : phase_inc[PER_W-1:0];

	assign idx_dividend = DIV_W'(phase_q) * DIV_W'(TABLE_ENTRIES);

	// Distance from the end is always at least one while a tone plays.
	assign dist_end = total_q - pos_q;
	assign fin_act  = pos_q < POS_W'(FADE_IN_SAMPLES);
	assign fout_act = (dist_end != '0) && (dist_end < POS_W'(FADE_OUT_SAMPLES));
	assign last_nx  = ({1'b0, pos_q} + 1'b1) >= {1'b0, total_q};

	// Fades work on the magnitude so that the division truncates toward zero,
	// and the sign goes back on after the multiply.
	assign smp_abs   = smp_q[15] ? (~smp_q + 1'b1) : smp_q;
	assign mul_b     = (state_q == ST_FIN_WAIT) ? pos_q[FADE_W-1:0] : dist_end[FADE_W-1:0];
	assign mul_p     = (MAG_W+FADE_W)'(div_rsp.quotient[MAG_W-1:0]) *
		(MAG_W+FADE_W)'(mul_b);
	assign faded_mag = {1'b0, mul_p[MAG_W-1:0]};
	assign faded     = smp_q[15] ? (~faded_mag + 1'b1) : faded_mag;

	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		div_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (start_req) begin
						if (tone_freq_q == '0) begin
							state_d = ST_EMIT;
						end else begin
							div_req.start    = 1'b1;
							div_req.dividend = DIV_W'(BASE_RATE);
							div_req.divisor  = tone_freq_q;
							state_d          = ST_PER_WAIT;
						end
					end else if (!playing_q) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_IDX_GO;
					end
				end
			end
			ST_PER_WAIT: begin
				if (div_rsp.done) begin
					state_d = per_ok ? ST_IDX_GO : ST_EMIT;
				end
			end
			ST_IDX_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = idx_dividend;
				div_req.divisor  = period_q;
				state_d          = ST_IDX_WAIT;
			end
			ST_IDX_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_FIN_CHK;
				end
			end
			ST_FIN_CHK: begin
				if (fin_act) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_W'(smp_abs[MAG_W-1:0]);
					div_req.divisor  = DEN_W'(FADE_IN_SAMPLES);
					state_d          = ST_FIN_WAIT;
				end else begin
					state_d = ST_FOUT_CHK;
				end
			end
			ST_FIN_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_FOUT_CHK;
				end
			end
			ST_FOUT_CHK: begin
				if (fout_act) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_W'(smp_abs[MAG_W-1:0]);
					div_req.divisor  = DEN_W'(FADE_OUT_SAMPLES);
					state_d          = ST_FOUT_WAIT;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_FOUT_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Tone state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			total_q   <= '0;
			phase_q   <= '0;
			period_q  <= '0;
			playing_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (start_req) begin
							// Any running tone is dropped; the period check decides
							// whether the new one starts.
							total_q   <= tot_sat;
							playing_q <= 1'b0;
						end else if (playing_q) begin
							pos_q   <= pos_q + 1'b1;
							phase_q <= phase_nx;
						end
					end
				end
				ST_PER_WAIT: begin
					if (div_rsp.done) begin
						if (per_ok) begin
							period_q  <= div_rsp.quotient[PER_W-1:0];
							pos_q     <= '0;
							phase_q   <= '0;
							playing_q <= 1'b1;
						end else begin
							playing_q <= 1'b0;
						end
					end
				end
				ST_IDX_WAIT: begin
					if (div_rsp.done && last_nx) begin
						playing_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result under construction.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					smp_q  <= '0;
					last_q <= 1'b0;
					if (start_req) begin
						status_q <= STAT_REJECT;
					end else begin
						status_q <= STAT_IDLE;
					end
				end
			end
			ST_PER_WAIT: begin
				if (div_rsp.done && !per_ok) begin
					smp_q    <= '0;
					last_q   <= 1'b0;
					status_q <= STAT_REJECT;
				end
			end
			ST_IDX_WAIT: begin
				if (div_rsp.done) begin
					smp_q    <= sine_value(div_rsp.quotient[IDX_W-1:0]);
					last_q   <= last_nx;
					status_q <= STAT_OK;
				end
			end
			ST_FIN_WAIT, ST_FOUT_WAIT: begin
				if (div_rsp.done) begin
					smp_q <= faded;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			m_sample_q <= smp_q;
			m_last_q   <= last_q;
			m_status_q <= status_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_sample_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_status_q;

`ifndef SYNTHESIS
	// The shared divider must be free whenever a new word can be taken.
	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> !div_rsp.busy)
		else $error("divider busy while input is ready");

	// A taken word always moves the sequencer out of the idle state, so the input drops ready.
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> !s_tready)
		else $error("input ready right after a word was taken");

	// A playing tone has a period and has not run past its end.
	assert property (@(posedge clk) disable iff (!arst_n)
		playing_q |-> (period_q != '0) && (pos_q < total_q))
		else $error("inconsistent tone state");

	// Idle and rejected results carry a silent, non-final sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == '0) && !m_tlast)
		else $error("nonzero sample on an idle or rejected result");
`endif

endmodule

`default_nettype wire
